[design/fmab_pkg.sv]
// Shared types, constants and sine table function for the FM/AM baseband modulator.
package fmab_pkg;

	// Default sizes of the datapath
	localparam int PHASE_BITS_DEF  = 32;
	localparam int ADDR_BITS_DEF   = 10;
	localparam int SAMPLE_BITS_DEF = 16;

	// Queue depths between the parts
	localparam int CMD_DEPTH = 4;
	localparam int OUT_DEPTH = 4;

	// Configuration port
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 32;
	localparam int MODE_BITS      = 2;
	localparam int GAIN_BITS      = 7;
	localparam int STEP_BITS      = 32;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_MODE        = 2'd0,
		REG_GAIN        = 2'd1,
		REG_WIDE_STEP   = 2'd2,
		REG_NARROW_STEP = 2'd3
	} cfg_reg_e;

	localparam logic [MODE_BITS-1:0] MODE_WIDE_FM   = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_NARROW_FM = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_AM        = 2'd2;

	localparam logic [MODE_BITS-1:0] MODE_RESET        = MODE_WIDE_FM;
	localparam logic [GAIN_BITS-1:0] GAIN_RESET        = 7'd90;
	localparam logic [STEP_BITS-1:0] WIDE_STEP_RESET   = 32'd113025455;
	localparam logic [STEP_BITS-1:0] NARROW_STEP_RESET = 32'd7535030;

	// Phase deviation divide by one hundred, done in two reciprocal steps.
	// The biased quotient X lies in (0, 100 * 2^34).
	localparam int DEV_BITS    = 32;
	localparam int X_BITS      = 41;
	localparam int LOW_BITS    = 21;
	localparam int HI_BITS     = X_BITS - LOW_BITS;
	localparam int Q1_BITS     = 13;
	localparam int REM_BITS    = 7;
	localparam int Y_BITS      = REM_BITS + LOW_BITS;
	localparam longint X_BIAS  = longint'(100) << 33;
	localparam int K1          = HI_BITS + 7;
	localparam logic [HI_BITS:0] M1 = (HI_BITS + 1)'(((64'd1 << K1) + 64'd99) / 64'd100);
	localparam int K2          = Y_BITS + 7;
	localparam logic [Y_BITS:0] M2 = (Y_BITS + 1)'(((64'd1 << K2) + 64'd99) / 64'd100);

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// One classified word between front and back
	typedef struct packed {
		logic                am;
		logic                eob;
		logic [DEV_BITS-1:0] arg;
	} cmd_t;

	// Magnitude of the sine at quarter-wave offset r, rounded to the sample grid
	function automatic logic [63:0] quarter_sine(input logic [63:0] r, input int qbits,
		input int sbits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		logic [63:0] lim;
		int          sh;
		x    = (r * HALF_PI_Q30) >> qbits;
		x2   = (x * x) >> 30;
		term = x;
		sum  = x;
		for (int k = 1; k <= 6; k++) begin
			term = (term * x2) >> 30;
			case (k)
				1: term = term / 64'd6;
				2: term = term / 64'd20;
				3: term = term / 64'd42;
				4: term = term / 64'd72;
				5: term = term / 64'd110;
				default: term = term / 64'd156;
			endcase
			if (k % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		sh  = 30 - (sbits - 1);
		v   = (sum + (64'd1 << (sh - 1))) >> sh;
		lim = (64'd1 << (sbits - 1)) - 64'd1;
		if (v > lim) begin
			v = lim;
		end
		return v;
	endfunction

endpackage

[design/fmab_fifo.sv]
// Small first-in first-out queue of words with occupancy count.
module fmab_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = fmab_pkg::CMD_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           din,
	output logic                       full,
	input  logic                       pop,
	output logic [WIDTH-1:0]           dout,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int CNT_BITS = $clog2(DEPTH + 1);
	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [PTR_BITS-1:0] LAST = PTR_BITS'(DEPTH - 1);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign full    = (count_q == CNT_BITS'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign dout    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[design/fmab_front.sv]
// Front part: configuration registers, gain, clipping and deviation or AM amplitude.
module fmab_front #(
	parameter int SAMPLE_BITS = fmab_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [fmab_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [fmab_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                push,
	output logic                                full,
	input  logic signed [SAMPLE_BITS-1:0]       pcm_sample,
	input  logic                                end_of_block,
	output logic                                cmd_push,
	output fmab_pkg::cmd_t                      cmd,
	input  logic                                cmd_full
);

	localparam int AMP_BITS  = SAMPLE_BITS + 8;
	localparam int PROD_BITS = AMP_BITS + 33;
	localparam int Z_BITS    = SAMPLE_BITS + 7;
	localparam int AMQ_BITS  = SAMPLE_BITS + 1;
	localparam int AMV_BITS  = SAMPLE_BITS + 2;
	localparam int K_AM      = Z_BITS + 7;
	localparam logic [Z_BITS:0] M_AM = (Z_BITS + 1)'(((64'd1 << K_AM) + 64'd99) / 64'd100);
	localparam longint FS_L  = longint'(100) << (SAMPLE_BITS - 1);
	localparam logic signed [AMP_BITS-1:0] FS      = AMP_BITS'(FS_L);
	localparam logic signed [AMP_BITS-1:0] FS_HALF = AMP_BITS'(FS_L / 2);
	localparam logic signed [AMV_BITS-1:0] OUT_MAX =
		AMV_BITS'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [AMV_BITS-1:0] HALF_RANGE =
		AMV_BITS'(longint'(1) << (SAMPLE_BITS - 1));

	typedef struct packed {
		logic valid;
		logic am;
		logic eob;
	} ctl_t;

	// Configuration registers
	logic [fmab_pkg::MODE_BITS-1:0] mode_q;
	logic [fmab_pkg::GAIN_BITS-1:0] gain_q;
	logic [fmab_pkg::STEP_BITS-1:0] wide_step_q;
	logic [fmab_pkg::STEP_BITS-1:0] narrow_step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= fmab_pkg::MODE_RESET;
			gain_q        <= fmab_pkg::GAIN_RESET;
			wide_step_q   <= fmab_pkg::WIDE_STEP_RESET;
			narrow_step_q <= fmab_pkg::NARROW_STEP_RESET;
		end else if (cfg_write) begin
			unique case (fmab_pkg::cfg_reg_e'(cfg_index))
				fmab_pkg::REG_MODE:        mode_q <= cfg_data[fmab_pkg::MODE_BITS-1:0];
				fmab_pkg::REG_GAIN:        gain_q <= cfg_data[fmab_pkg::GAIN_BITS-1:0];
				fmab_pkg::REG_WIDE_STEP:   wide_step_q <= cfg_data[fmab_pkg::STEP_BITS-1:0];
				fmab_pkg::REG_NARROW_STEP: narrow_step_q <= cfg_data[fmab_pkg::STEP_BITS-1:0];
				default: ;
			endcase
		end
	end

	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	logic stall;
	logic adv;
	logic accept;

	// Hold every stage while the last one waits on a full queue
	assign stall    = ctl_s6.valid && cmd_full;
	assign adv      = !stall;
	assign full     = stall;
	assign accept   = push && !stall;
	assign cmd_push = ctl_s6.valid && !cmd_full;

	// Stage 1: gain
	logic signed [AMP_BITS-1:0]     amp_in;
	logic signed [AMP_BITS-1:0]     amp_s1;
	logic [fmab_pkg::STEP_BITS-1:0] step_s1;

	assign amp_in = AMP_BITS'(pcm_sample) * AMP_BITS'($signed({1'b0, gain_q}));

	// Stage 2: clip; deviation product or biased AM amplitude
	logic signed [AMP_BITS-1:0]  clip_fm;
	logic signed [AMP_BITS-1:0]  am_sum;
	logic signed [AMP_BITS-1:0]  clip_am;
	logic signed [AMP_BITS-1:0]  am_biased;
	logic signed [PROD_BITS-1:0] prod_s2;
	logic [Z_BITS-1:0]           z_s2;

	always_comb begin
		if (amp_s1 > FS) begin
			clip_fm = FS;
		end else if (amp_s1 < -FS) begin
			clip_fm = -FS;
		end else begin
			clip_fm = amp_s1;
		end
		am_sum = amp_s1 + FS_HALF;
		if (am_sum > FS) begin
			clip_am = FS;
		end else if (am_sum < -FS) begin
			clip_am = -FS;
		end else begin
			clip_am = am_sum;
		end
		am_biased = clip_am + FS + AMP_BITS'(50);
	end

	// Stage 3: round and bias the deviation; AM divide by one hundred
	logic signed [PROD_BITS-1:0]     rnd;
	logic signed [PROD_BITS-1:0]     x_full;
	logic [fmab_pkg::X_BITS-1:0]     x_s3;
	logic [2*Z_BITS:0]               am_prod;
	logic [AMQ_BITS-1:0]             am_q_s3;

	assign rnd     = prod_s2 + PROD_BITS'(FS_HALF);
	assign x_full  = (rnd >>> (SAMPLE_BITS - 1)) + PROD_BITS'(fmab_pkg::X_BIAS);
	assign am_prod = (2 * Z_BITS + 1)'(z_s2) * (2 * Z_BITS + 1)'(M_AM);

	// Stage 4: high quotient of the deviation; AM saturation
	logic [fmab_pkg::HI_BITS-1:0]          hi_x;
	logic [fmab_pkg::HI_BITS+fmab_pkg::K1:0] q1_prod;
	logic [fmab_pkg::Q1_BITS-1:0]          q1_s4;
	logic [fmab_pkg::HI_BITS-1:0]          hi_s4;
	logic [fmab_pkg::LOW_BITS-1:0]         lo_s4;
	logic signed [AMV_BITS-1:0]            am_v;
	logic signed [AMV_BITS-1:0]            am_sat;
	logic [fmab_pkg::DEV_BITS-1:0]         arg_s4;

	localparam int Q1P_BITS = fmab_pkg::HI_BITS + fmab_pkg::K1 + 1;

	assign hi_x    = x_s3[fmab_pkg::X_BITS-1 -: fmab_pkg::HI_BITS];
	assign q1_prod = Q1P_BITS'(hi_x) * Q1P_BITS'(fmab_pkg::M1);

	always_comb begin
		am_v = $signed({1'b0, am_q_s3}) - HALF_RANGE;
		if (am_v > OUT_MAX) begin
			am_sat = OUT_MAX;
		end else if (am_v < -OUT_MAX) begin
			am_sat = -OUT_MAX;
		end else begin
			am_sat = am_v;
		end
	end

	// Stage 5: remainder joined with the low bits
	logic [fmab_pkg::HI_BITS-1:0]  rem_full;
	logic [fmab_pkg::Y_BITS-1:0]   y_s5;
	logic [fmab_pkg::Q1_BITS-1:0]  q1_s5;
	logic [fmab_pkg::DEV_BITS-1:0] arg_s5;

	assign rem_full = hi_s4 - fmab_pkg::HI_BITS'(q1_s4) * fmab_pkg::HI_BITS'(100);

	// Stage 6: low quotient, assemble the deviation
	localparam int Q2P_BITS = fmab_pkg::Y_BITS + fmab_pkg::K2 + 1;
	localparam int DEVF_BITS = fmab_pkg::Q1_BITS + fmab_pkg::LOW_BITS;

	logic [Q2P_BITS-1:0]           q2_prod;
	logic [fmab_pkg::LOW_BITS-1:0] q2;
	logic [DEVF_BITS-1:0]          dev_full;
	logic [fmab_pkg::DEV_BITS-1:0] arg_s6;

	assign q2_prod  = Q2P_BITS'(y_s5) * Q2P_BITS'(fmab_pkg::M2);
	assign q2       = q2_prod[fmab_pkg::K2 +: fmab_pkg::LOW_BITS];
	assign dev_full = {q1_s5, q2};

	assign cmd.am  = ctl_s6.am;
	assign cmd.eob = ctl_s6.eob;
	assign cmd.arg = arg_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
		end else if (adv) begin
			ctl_s1 <= '{valid: accept, am: mode_q[1], eob: end_of_block};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			amp_s1  <= amp_in;
			step_s1 <= (mode_q == fmab_pkg::MODE_WIDE_FM) ? wide_step_q : narrow_step_q;
			prod_s2 <= PROD_BITS'(clip_fm) * PROD_BITS'($signed({1'b0, step_s1}));
			z_s2    <= am_biased[Z_BITS-1:0];
			x_s3    <= x_full[fmab_pkg::X_BITS-1:0];
			am_q_s3 <= am_prod[K_AM +: AMQ_BITS];
			q1_s4   <= q1_prod[fmab_pkg::K1 +: fmab_pkg::Q1_BITS];
			hi_s4   <= hi_x;
			lo_s4   <= x_s3[fmab_pkg::LOW_BITS-1:0];
			arg_s4  <= fmab_pkg::DEV_BITS'(am_sat);
			y_s5    <= {rem_full[fmab_pkg::REM_BITS-1:0], lo_s4};
			q1_s5   <= q1_s4;
			arg_s5  <= arg_s4;
			arg_s6  <= ctl_s5.am ? arg_s5 : dev_full[fmab_pkg::DEV_BITS-1:0];
		end
	end

endmodule

[design/fmab_back.sv]
// Back part: phase accumulator, quarter-wave sine ROM and I/Q assembly.
module fmab_back #(
	parameter int PHASE_BITS  = fmab_pkg::PHASE_BITS_DEF,
	parameter int ADDR_BITS   = fmab_pkg::ADDR_BITS_DEF,
	parameter int SAMPLE_BITS = fmab_pkg::SAMPLE_BITS_DEF,
	parameter int OUT_DEPTH   = fmab_pkg::OUT_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_empty,
	input  fmab_pkg::cmd_t                 cmd,
	output logic                           cmd_pop,
	input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
	output logic                           out_push,
	output logic [2*SAMPLE_BITS:0]         out_data
);

	localparam int QB        = ADDR_BITS - 2;
	localparam int ROM_DEPTH = (1 << QB) + 1;
	localparam int IDX_BITS  = QB + 1;
	localparam int MAG_BITS  = SAMPLE_BITS - 1;
	localparam int CNT_BITS  = $clog2(OUT_DEPTH + 1);
	localparam logic [IDX_BITS-1:0] QUARTER_FULL = IDX_BITS'(1) << QB;

	typedef logic [MAG_BITS-1:0] rom_t [ROM_DEPTH];

	function automatic rom_t build_rom();
		rom_t t;
		for (int i = 0; i < ROM_DEPTH; i++) begin
			t[i] = MAG_BITS'(fmab_pkg::quarter_sine(64'(i), QB, SAMPLE_BITS));
		end
		return t;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	// Take a word only when the output queue has room for everything in flight
	logic [CNT_BITS:0] in_use;
	logic              valid_b1;
	logic              valid_b2;

	assign in_use  = (CNT_BITS + 1)'(out_count) + (CNT_BITS + 1)'(valid_b1)
		+ (CNT_BITS + 1)'(valid_b2);
	assign cmd_pop = !cmd_empty && (in_use < (CNT_BITS + 1)'(OUT_DEPTH));

	// Phase step from the deviation in units of 2^-32 turn
	logic [PHASE_BITS-1:0] phase_inc;

	generate
		if (PHASE_BITS >= fmab_pkg::DEV_BITS) begin : g_wide_phase
			assign phase_inc = PHASE_BITS'(cmd.arg) << (PHASE_BITS - fmab_pkg::DEV_BITS);
		end else begin : g_narrow_phase
			assign phase_inc = cmd.arg[fmab_pkg::DEV_BITS-1 -: PHASE_BITS];
		end
	endgenerate

	logic [PHASE_BITS-1:0] phase_q;
	logic [PHASE_BITS-1:0] phase_next;
	logic [ADDR_BITS-1:0]  addr;
	logic [1:0]            sin_quad;
	logic [1:0]            cos_quad;
	logic [IDX_BITS-1:0]   r_ext;
	logic [IDX_BITS-1:0]   sin_idx;
	logic [IDX_BITS-1:0]   cos_idx;

	assign phase_next = phase_q + phase_inc;
	assign addr       = phase_next[PHASE_BITS-1 -: ADDR_BITS];
	assign sin_quad   = addr[ADDR_BITS-1 -: 2];
	assign cos_quad   = sin_quad + 2'd1;
	assign r_ext      = {1'b0, addr[QB-1:0]};
	assign sin_idx    = sin_quad[0] ? (QUARTER_FULL - r_ext) : r_ext;
	assign cos_idx    = cos_quad[0] ? (QUARTER_FULL - r_ext) : r_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			valid_b1 <= 1'b0;
			valid_b2 <= 1'b0;
		end else begin
			valid_b1 <= cmd_pop;
			valid_b2 <= valid_b1;
			if (cmd_pop && !cmd.am) begin
				phase_q <= phase_next;
			end
		end
	end

	// Stage b1: ROM addresses and signs
	logic                   am_b1;
	logic                   eob_b1;
	logic [SAMPLE_BITS-1:0] am_val_b1;
	logic [IDX_BITS-1:0]    sin_idx_b1;
	logic [IDX_BITS-1:0]    cos_idx_b1;
	logic                   sin_neg_b1;
	logic                   cos_neg_b1;

	// Stage b2: ROM data
	logic                   am_b2;
	logic                   eob_b2;
	logic [SAMPLE_BITS-1:0] am_val_b2;
	logic [MAG_BITS-1:0]    sin_mag_b2;
	logic [MAG_BITS-1:0]    cos_mag_b2;
	logic                   sin_neg_b2;
	logic                   cos_neg_b2;

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			am_b1      <= cmd.am;
			eob_b1     <= cmd.eob;
			am_val_b1  <= cmd.arg[SAMPLE_BITS-1:0];
			sin_idx_b1 <= sin_idx;
			cos_idx_b1 <= cos_idx;
			sin_neg_b1 <= sin_quad[1];
			cos_neg_b1 <= cos_quad[1];
		end
		am_b2      <= am_b1;
		eob_b2     <= eob_b1;
		am_val_b2  <= am_val_b1;
		sin_mag_b2 <= SINE_ROM[sin_idx_b1];
		cos_mag_b2 <= SINE_ROM[cos_idx_b1];
		sin_neg_b2 <= sin_neg_b1;
		cos_neg_b2 <= cos_neg_b1;
	end

	logic signed [SAMPLE_BITS-1:0] sin_pos;
	logic signed [SAMPLE_BITS-1:0] cos_pos;
	logic signed [SAMPLE_BITS-1:0] i_val;
	logic signed [SAMPLE_BITS-1:0] q_val;

	always_comb begin
		sin_pos = $signed({1'b0, sin_mag_b2});
		cos_pos = $signed({1'b0, cos_mag_b2});
		if (am_b2) begin
			i_val = $signed(am_val_b2);
			q_val = '0;
		end else begin
			i_val = sin_neg_b2 ? -sin_pos : sin_pos;
			q_val = cos_neg_b2 ? -cos_pos : cos_pos;
		end
	end

	assign out_push = valid_b2;
	assign out_data = {eob_b2, i_val, q_val};

endmodule

[design/fm_am_baseband_modulator.sv]
// FM/AM baseband modulator: one audio word in, one I/Q word out.
// Path of a word: front stages s1 to s6, command queue, back stages b1 and b2, output queue.
// Throughput: one word per cycle; the front stalls only when the command queue fills,
// and the back takes a command only while the output queue has room for it.
// Reset: arst_n clears all queues and valid bits, zeroes the phase accumulator and
// loads mode wide FM, gain 90 percent and the default deviation steps.
module fm_am_baseband_modulator #(
	parameter int PHASE_BITS           = fmab_pkg::PHASE_BITS_DEF,
	parameter int SINE_TABLE_ADDR_BITS = fmab_pkg::ADDR_BITS_DEF,
	parameter int SAMPLE_BITS          = fmab_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_write,
	input  logic [fmab_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [fmab_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	// input words
	input  logic                                push,
	output logic                                full,
	input  logic signed [SAMPLE_BITS-1:0]       pcm_sample,
	input  logic                                end_of_block,
	// result words
	output logic                                empty,
	input  logic                                pop,
	output logic signed [SAMPLE_BITS-1:0]       in_phase,
	output logic signed [SAMPLE_BITS-1:0]       quadrature,
	output logic                                block_end
);

	localparam int CMD_WIDTH = $bits(fmab_pkg::cmd_t);
	localparam int OUT_WIDTH = 2 * SAMPLE_BITS + 1;
	localparam int OUT_CNT_BITS = $clog2(fmab_pkg::OUT_DEPTH + 1);

	// Front to command queue
	logic           front_push;
	fmab_pkg::cmd_t front_cmd;
	logic           cmd_full;

	// Command queue to back
	logic           cmd_empty;
	logic           cmd_pop;
	fmab_pkg::cmd_t back_cmd;
	logic [CMD_WIDTH-1:0] back_cmd_bits;

	// Back to output queue
	logic                    out_push;
	logic [OUT_WIDTH-1:0]    out_din;
	logic [OUT_WIDTH-1:0]    out_dout;
	logic [OUT_CNT_BITS-1:0] out_count;

	// Front: gain, clipping and the divide by full scale. Each word leaves
	// as either an AM amplitude or a phase deviation.
	fmab_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.push         (push),
		.full         (full),
		.pcm_sample   (pcm_sample),
		.end_of_block (end_of_block),
		.cmd_push     (front_push),
		.cmd          (front_cmd),
		.cmd_full     (cmd_full)
	);

	// Command queue decouples the front pipeline from the back
	fmab_fifo #(
		.WIDTH (CMD_WIDTH),
		.DEPTH (fmab_pkg::CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_push),
		.din    (front_cmd),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.dout   (back_cmd_bits),
		.empty  (cmd_empty),
		.count  ()
	);

	assign back_cmd = fmab_pkg::cmd_t'(back_cmd_bits);

	// Back: advance the phase in order, read sine and cosine from the ROM
	fmab_back #(
		.PHASE_BITS  (PHASE_BITS),
		.ADDR_BITS   (SINE_TABLE_ADDR_BITS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.OUT_DEPTH   (fmab_pkg::OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (back_cmd),
		.cmd_pop   (cmd_pop),
		.out_count (out_count),
		.out_push  (out_push),
		.out_data  (out_din)
	);

	// Output queue holds finished words until the consumer pops them
	fmab_fifo #(
		.WIDTH (OUT_WIDTH),
		.DEPTH (fmab_pkg::OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.din    (out_din),
		.full   (),
		.pop    (pop),
		.dout   (out_dout),
		.empty  (empty),
		.count  (out_count)
	);

	// Unpack the head word onto the result ports
	assign block_end  = out_dout[2*SAMPLE_BITS];
	assign in_phase   = $signed(out_dout[2*SAMPLE_BITS-1 -: SAMPLE_BITS]);
	assign quadrature = $signed(out_dout[SAMPLE_BITS-1:0]);

endmodule

[test/fmab_checker.sv]
// Checker for the FM/AM baseband modulator: predicts each I/Q word and compares it with the output.
`timescale 1ns / 1ps
module fmab_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [fmab_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [fmab_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                push,
	input  logic                                full,
	input  logic signed [15:0]                  pcm_sample,
	input  logic                                end_of_block,
	input  logic                                empty,
	input  logic                                pop,
	input  logic signed [15:0]                  in_phase,
	input  logic signed [15:0]                  quadrature,
	input  logic                                block_end,
	output int                                  mismatches,
	output int                                  pending,
	output int                                  words_checked
);

	localparam int     SAMPLE_W     = fmab_pkg::SAMPLE_BITS_DEF;
	localparam int     ROM_BITS     = fmab_pkg::ADDR_BITS_DEF;
	localparam int     ROM_DEPTH    = 1 << ROM_BITS;
	localparam int     QUARTER_BITS = ROM_BITS - 2;
	localparam int     QUARTER      = 1 << QUARTER_BITS;
	localparam int     ROUND_SHIFT  = 30 - (SAMPLE_W - 1);
	localparam longint FULL_SCALE   = longint'(100) << (SAMPLE_W - 1);
	localparam longint OUT_LIMIT    = (longint'(1) << (SAMPLE_W - 1)) - 1;

	typedef struct {
		logic signed [SAMPLE_W-1:0] i_val;
		logic signed [SAMPLE_W-1:0] q_val;
		logic                       eob;
	} iq_word_t;

	logic signed [SAMPLE_W-1:0] sine_rom [ROM_DEPTH];
	iq_word_t                   expected_words [$];

	logic [fmab_pkg::MODE_BITS-1:0] mode;
	logic [fmab_pkg::GAIN_BITS-1:0] gain;
	logic [fmab_pkg::STEP_BITS-1:0] wide_step;
	logic [fmab_pkg::STEP_BITS-1:0] narrow_step;
	logic [31:0]                    phase;

	function automatic longint div_floor(input longint num, input longint den);
		longint q;
		q = num / den;
		if ((num % den) != 0 && num < 0) begin
			q--;
		end
		return q;
	endfunction

	function automatic longint div_round(input longint num, input longint den);
		return div_floor(num + den / 2, den);
	endfunction

	function automatic longint clip_full_scale(input longint v);
		return (v > FULL_SCALE) ? FULL_SCALE : (v < -FULL_SCALE) ? -FULL_SCALE : v;
	endfunction

	function automatic longint saturate(input longint v);
		return (v > OUT_LIMIT) ? OUT_LIMIT : (v < -OUT_LIMIT) ? -OUT_LIMIT : v;
	endfunction

	// Taylor series of the sine up to x^13 on a Q30 angle, each term floored
	function automatic longint sine_magnitude(input int unsigned offset);
		logic [63:0] angle;
		logic [63:0] angle_sq;
		logic [63:0] term;
		logic [63:0] series;
		logic [63:0] mag;
		angle    = (64'(offset) * fmab_pkg::HALF_PI_Q30) >> QUARTER_BITS;
		angle_sq = (angle * angle) >> 30;
		term     = angle;
		series   = angle;
		for (int k = 1; k <= 6; k++) begin
			term   = ((term * angle_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
			series = (k % 2 == 1) ? series - term : series + term;
		end
		mag = (series + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
		return (mag > 64'(OUT_LIMIT)) ? OUT_LIMIT : longint'(mag);
	endfunction

	initial begin
		int unsigned quad;
		int unsigned offset;
		longint      mag;
		for (int a = 0; a < ROM_DEPTH; a++) begin
			quad   = a / QUARTER;
			offset = a % QUARTER;
			mag    = sine_magnitude((quad % 2 == 1) ? QUARTER - offset : offset);
			sine_rom[a] = SAMPLE_W'((quad >= 2) ? -mag : mag);
		end
	end

	task automatic modulate(input logic signed [SAMPLE_W-1:0] sample, input logic eob,
		output iq_word_t w);
		longint               amp;
		longint               step;
		longint               dev;
		logic [ROM_BITS-1:0]  sin_addr;
		logic [ROM_BITS-1:0]  cos_addr;
		amp   = longint'(sample) * longint'(gain);
		w.eob = eob;
		if (mode[1]) begin
			// AM and mode three: offset by one half, phase holds
			w.i_val = SAMPLE_W'(saturate(div_round(
				clip_full_scale(amp + FULL_SCALE / 2), 100)));
			w.q_val = '0;
		end else begin
			step     = (mode == fmab_pkg::MODE_WIDE_FM) ? longint'(wide_step)
				: longint'(narrow_step);
			dev      = div_round(clip_full_scale(amp) * step, FULL_SCALE);
			phase    = phase + dev[31:0];
			sin_addr = phase[31 -: ROM_BITS];
			cos_addr = sin_addr + ROM_BITS'(QUARTER);
			w.i_val  = sine_rom[sin_addr];
			w.q_val  = sine_rom[cos_addr];
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		iq_word_t w;
		iq_word_t exp_w;
		int       errs;
		if (!arst_n) begin
			mode        <= fmab_pkg::MODE_RESET;
			gain        <= fmab_pkg::GAIN_RESET;
			wide_step   <= fmab_pkg::WIDE_STEP_RESET;
			narrow_step <= fmab_pkg::NARROW_STEP_RESET;
			phase        = '0;
			expected_words.delete();
			mismatches    <= 0;
			pending       <= 0;
			words_checked <= 0;
		end else begin
			errs = 0;
			if (cfg_write) begin
				case (cfg_index)
					fmab_pkg::REG_MODE:
						mode        <= cfg_data[fmab_pkg::MODE_BITS-1:0];
					fmab_pkg::REG_GAIN:
						gain        <= cfg_data[fmab_pkg::GAIN_BITS-1:0];
					fmab_pkg::REG_WIDE_STEP:
						wide_step   <= cfg_data[fmab_pkg::STEP_BITS-1:0];
					fmab_pkg::REG_NARROW_STEP:
						narrow_step <= cfg_data[fmab_pkg::STEP_BITS-1:0];
					default: ;
				endcase
			end
			if (push && !full) begin
				modulate(pcm_sample, end_of_block, w);
				expected_words.push_back(w);
			end
			if (pop && !empty) begin
				if (expected_words.size() == 0) begin
					$error("result word with no expectation: in_phase %0d %s %0d %s %0b",
						in_phase, "quadrature", quadrature, "block_end", block_end);
					errs++;
				end else begin
					exp_w = expected_words.pop_front();
					words_checked <= words_checked + 1;
					if (in_phase !== exp_w.i_val) begin
						$error("in_phase: expected %0d, actual %0d", exp_w.i_val, in_phase);
						errs++;
					end
					if (quadrature !== exp_w.q_val) begin
						$error("quadrature: expected %0d, actual %0d", exp_w.q_val,
							quadrature);
						errs++;
					end
					if (block_end !== exp_w.eob) begin
						$error("block_end: expected %0b, actual %0b", exp_w.eob, block_end);
						errs++;
					end
				end
			end
			mismatches <= mismatches + errs;
			pending    <= expected_words.size();
		end
	end

endmodule

[test/testbench.sv]
// Top of the modulator testbench: clock, reset, stimulus, traffic shaping and the verdict.
`timescale 1ns / 1ps
module testbench;

	// Mode three has no name in the package; the upper mode bit makes it AM
	localparam logic [fmab_pkg::MODE_BITS-1:0] MODE_AM_ALT = 2'd3;
	localparam int HOLD_CYCLES    = 400;
	localparam int SEGMENTS       = 6;
	localparam int SEGMENT_WORDS  = 100;
	localparam int CYCLE_LIMIT    = 300000;

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                cfg_write;
	logic [fmab_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [fmab_pkg::CFG_DATA_BITS-1:0]  cfg_data;
	logic                                push;
	logic                                full;
	logic signed [15:0]                  pcm_sample;
	logic                                end_of_block;
	logic                                empty;
	logic                                pop;
	logic signed [15:0]                  in_phase;
	logic signed [15:0]                  quadrature;
	logic                                block_end;

	int mismatches;
	int pending;
	int words_checked;

	// Idle odds in percent for each side, and the request for a long output hold-off
	int unsigned send_idle;
	int unsigned recv_idle;
	bit          hold_req;
	int          settings_count;
	longint      cycle_count;

	fm_am_baseband_modulator dut (.*);
	fmab_checker u_checker (.*);

	always #4 clk = ~clk;

	// Timeout: count cycles and give up well past the slowest correct run
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// Receiver: pop at random, or hold pop low for a long stretch when asked
	initial begin
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= recv_idle);
			end
		end
	end

	// Offer one word and hold it until the block takes it; full is sampled at the
	// falling edge so the decision never races the block's own update.
	task automatic send_word(input logic signed [15:0] sample, input logic eob);
		logic taken;
		while ($urandom_range(0, 99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push         <= 1'b1;
		pcm_sample   <= sample;
		end_of_block <= eob;
		do begin
			@(negedge clk);
			taken = !full;
			@(posedge clk);
		end while (!taken);
	endtask

	// Drop push and wait until every expected word has come out
	task automatic drain();
		push <= 1'b0;
		@(negedge clk);
		wait (pending == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input fmab_pkg::cfg_reg_e idx,
		input logic [fmab_pkg::CFG_DATA_BITS-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	// Write all four registers back to back, then release the write enable
	task automatic apply_config(input logic [fmab_pkg::MODE_BITS-1:0] mode,
		input logic [fmab_pkg::GAIN_BITS-1:0] gain,
		input logic [fmab_pkg::STEP_BITS-1:0] wide,
		input logic [fmab_pkg::STEP_BITS-1:0] narrow);
		drain();
		write_reg(fmab_pkg::REG_MODE, fmab_pkg::CFG_DATA_BITS'(mode));
		write_reg(fmab_pkg::REG_GAIN, fmab_pkg::CFG_DATA_BITS'(gain));
		write_reg(fmab_pkg::REG_WIDE_STEP, wide);
		write_reg(fmab_pkg::REG_NARROW_STEP, narrow);
		cfg_write <= 1'b0;
		settings_count++;
	endtask

	function automatic logic [fmab_pkg::STEP_BITS-1:0] pick_step();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			2: return $urandom >> $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [fmab_pkg::GAIN_BITS-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 7'd100;
			2: return '1;
			default: return fmab_pkg::GAIN_BITS'($urandom_range(0, 127));
		endcase
	endfunction

	// Full-scale samples show up often enough to exercise clipping in every mode
	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'($urandom_range(0, 3)) - 16'sd1;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		arst_n       <= 1'b0;
		cfg_write    <= 1'b0;
		cfg_index    <= fmab_pkg::REG_MODE;
		cfg_data     <= '0;
		push         <= 1'b0;
		pcm_sample   <= '0;
		end_of_block <= 1'b0;
		send_idle      = 0;
		recv_idle      = 0;
		hold_req       = 1'b0;
		settings_count = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: reset register values, full-scale words and both flag values
		send_word(16'sh7fff, 1'b0);
		send_word(16'sh8000, 1'b1);
		send_word(16'sd0, 1'b0);
		send_word(-16'sd1, 1'b1);

		// Gain above one hundred with the largest wide step: clipping bounds the deviation
		apply_config(fmab_pkg::MODE_WIDE_FM, 7'd127, '1, '0);
		send_word(16'sh7fff, 1'b1);
		send_word(16'sh8000, 1'b0);
		send_word(16'sd1, 1'b1);
		send_word(-16'sd1, 1'b0);

		// Narrow FM at unity gain with the largest narrow step
		apply_config(fmab_pkg::MODE_NARROW_FM, 7'd100, '0, '1);
		send_word(16'sh7fff, 1'b0);
		send_word(16'sh8000, 1'b1);
		send_word(16'sd16384, 1'b0);
		send_word(16'sd0, 1'b1);

		// AM: plus full scale saturates, minus one half lands on zero
		apply_config(fmab_pkg::MODE_AM, 7'd100, fmab_pkg::WIDE_STEP_RESET,
			fmab_pkg::NARROW_STEP_RESET);
		send_word(16'sh7fff, 1'b1);
		send_word(16'sh8000, 1'b0);
		send_word(-16'sd16384, 1'b1);
		send_word(16'sd0, 1'b0);
		send_word(16'sd1, 1'b1);

		// Mode three behaves as AM; zero gain leaves only the offset
		apply_config(MODE_AM_ALT, 7'd0, '1, '1);
		send_word(16'sh7fff, 1'b0);
		send_word(16'sh8000, 1'b1);

		// Zero gain in FM: phase stays put
		apply_config(fmab_pkg::MODE_NARROW_FM, 7'd0, '1, '1);
		send_word(16'sd12345, 1'b1);

		// Random: three traffic mixes, each over several register settings
		for (int mix = 0; mix < 3; mix++) begin
			case (mix)
				0: begin
					send_idle = 16;
					recv_idle = 88;
				end
				1: begin
					send_idle = 88;
					recv_idle = 16;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			for (int seg = 0; seg < SEGMENTS; seg++) begin
				apply_config(fmab_pkg::MODE_BITS'($urandom_range(0, 3)), pick_gain(),
					pick_step(), pick_step());
				// Stall the output while the sender keeps pushing so the block backs up
				if (mix == 2 && seg == 1) begin
					hold_req = 1'b1;
				end
				repeat (SEGMENT_WORDS) begin
					send_word(pick_sample(), ($urandom_range(0, 7) == 0));
				end
			end
		end

		drain();
		repeat (20) @(posedge clk);

		$display("Checked %0d I/Q words over %0d register settings in wide FM, narrow FM, AM",
			words_checked, settings_count);
		$display("and mode three, with mixed idling and a %0d-cycle output stall.", HOLD_CYCLES);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
